@@ rtl/core/pda_pkg.sv @@
// Shared types and constants of the population distance accumulator.
package pda_pkg;

	// Operation codes of an input transaction.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_CAND = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_METHOD = 1'b0;
	localparam logic CFG_COUNT  = 1'b1;

	// Distance methods.
	localparam logic METHOD_BITS = 1'b0;
	localparam logic METHOD_EUCL = 1'b1;

	// Saturation limits of the 48-bit result.
	localparam logic [48:0] OVL_LIMIT = 49'h1_0000_0000_0000 >> 1;
	localparam logic [48:0] POS_LIMIT = (49'h1_0000_0000_0000 >> 1) - 49'd1;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CQS,
		S_CQW,
		S_RD,
		S_AQS,
		S_AQW,
		S_ACC,
		S_FS,
		S_FW,
		S_FA,
		S_EMIT
	} pda_state_t;

endpackage

@@ rtl/core/pda_cell.sv @@
// One cell of the ring that holds the per-antigen squared-difference sums.
module pda_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift,
	input  logic [63:0] din,
	output logic [63:0] dout
);
	logic [63:0] sum_q;

	// The sum moves one cell toward the head on every shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift) begin
			sum_q <= din;
		end
	end

	assign dout = sum_q;
endmodule

@@ rtl/core/pda_quant.sv @@
// Quantizer: floor((v - lb) * (2^QB - 1) / (ub - lb)), one quotient bit a cycle.
module pda_quant #(
	parameter int QB = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic signed [31:0] v,
	input  logic signed [31:0] lb,
	input  logic signed [31:0] ub,
	output logic              done,
	output logic [QB-1:0]     q
);
	localparam int CW = $clog2(QB + 1);
	localparam logic [QB-1:0] TOP = '1;

	logic signed [32:0] d;
	logic signed [32:0] r;
	logic               busy_q;
	logic               mul_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [31+QB:0]     prod_q;
	logic [31:0]        rem_q;
	logic [31:0]        r_q;
	logic [QB-1:0]      lo_q;
	logic [QB-1:0]      quo_q;
	logic [32:0]        t;
	logic [32:0]        t_sub;
	logic               ge;
	logic [QB:0]        quo_next;

	// Offsets from the lower bound, exact in 33 bits.
	assign d = {v[31], v} - {lb[31], lb};
	assign r = {ub[31], ub} - {lb[31], lb};

	// One restoring division step.
	assign t        = {rem_q, lo_q[QB-1]};
	assign t_sub    = t - {1'b0, r_q};
	assign ge       = t >= {1'b0, r_q};
	assign quo_next = {quo_q, ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (r <= 33'sd0 || d <= 33'sd0 || d >= r) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					mul_q  <= 1'b1;
				end
			end else if (mul_q) begin
				mul_q <= 1'b0;
				cnt_q <= CW'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the quantizer.
	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= r[31:0];
			prod_q <= (32 + QB)'(d[31:0]) * (32 + QB)'(TOP);
			if (r <= 33'sd0 || d <= 33'sd0) begin
				quo_q <= '0;
			end else if (d >= r) begin
				quo_q <= TOP;
			end else begin
				quo_q <= '0;
			end
		end else if (mul_q) begin
			rem_q <= prod_q[31+QB:QB];
			lo_q  <= prod_q[QB-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? t_sub[31:0] : t[31:0];
			lo_q  <= lo_q << 1;
			quo_q <= quo_next[QB-1:0];
		end
	end

	assign done = done_q;
	assign q    = quo_q;
endmodule

@@ rtl/core/pda_isqrt.sv @@
// Integer square root of a 64-bit value, two radicand bits a cycle.
module pda_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] din,
	output logic        done,
	output logic [31:0] root
);
	logic        busy_q;
	logic        done_q;
	logic [63:0] s_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 64'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// One digit-recurrence step per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			s_q   <= din;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (s_q >= trial) begin
				s_q   <= s_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];
endmodule

@@ rtl/core/population_distance_accumulator_top.sv @@
// Top level of the population distance accumulator.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall    op, antigen_index, gene_index, value,
//                                             lower_bound, upper_bound, last
//  out      output     out_valid / out_stall  distance
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load is written straight into the antigen store. A candidate gene is first quantized by the
// quantizer; then each antigen in use is read, quantized and accumulated, and each unused ring
// cell is only shifted on. The last gene adds a pass over every ring cell, with a square root
// per antigen in use in euclidean mode. Reset clears the ring, the totals, the state and the
// configuration registers, but not the antigen store or the payload registers.
// A finished result waits in the output register while the next item is taken.
module population_distance_accumulator_top #(
	parameter int MAX_ANTIGENS = 64,
	parameter int MAX_DIMS     = 16,
	parameter int QUANT_BITS   = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [5:0]         antigen_index,
	input  logic [3:0]         gene_index,
	input  logic signed [31:0] value,
	input  logic signed [31:0] lower_bound,
	input  logic signed [31:0] upper_bound,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] distance,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [6:0]         cfg_data
);
	import pda_pkg::*;

	localparam int DEPTH = MAX_ANTIGENS * MAX_DIMS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int JW    = (MAX_ANTIGENS > 1) ? $clog2(MAX_ANTIGENS) : 1;

	pda_state_t state_q;
	pda_state_t state_d;

	logic                    method_q;
	logic [6:0]              count_q;
	logic [8:0]              n_act;
	logic                    in_acc;
	logic                    load_we;
	logic [AW-1:0]           wr_addr;
	logic [AW-1:0]           rd_addr;
	logic [31:0]             mem [DEPTH];
	logic [31:0]             mem_rd_q;
	logic [3:0]              gi_q;
	logic signed [31:0]      v_q;
	logic signed [31:0]      lb_q;
	logic signed [31:0]      ub_q;
	logic                    last_q;
	logic [JW-1:0]           j_q;
	logic                    j_last;
	logic                    active;
	logic [QUANT_BITS-1:0]   qx_q;
	logic [63:0]             sq_q;
	logic [47:0]             overlap_q;
	logic [47:0]             sum_q;
	logic                    out_valid_q;
	logic [47:0]             dist_q;
	logic                    emit_go;
	logic                    gi_ok;
	logic                    q_start;
	logic                    q_done;
	logic signed [31:0]      q_v;
	logic [QUANT_BITS-1:0]   q_val;
	logic                    r_start;
	logic                    r_done;
	logic [31:0]             root;
	logic                    ring_shift;
	logic [63:0]             ring_tail;
	logic [63:0]             ring [MAX_ANTIGENS];
	logic signed [32:0]      diff;
	logic [32:0]             mag;
	logic [64:0]             sq_sum;
	logic [5:0]              pc;
	logic [48:0]             ovl_next;
	logic [48:0]             sum_next;

	// Number of set bits of a quantized word.
	function automatic logic [5:0] popcount(input logic [QUANT_BITS-1:0] x);
		logic [5:0] c;
		c = '0;
		for (int i = 0; i < QUANT_BITS; i++) begin
			c = c + 6'(x[i]);
		end
		return c;
	endfunction

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_BITS;
			count_q  <= 7'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_METHOD: method_q <= cfg_data[0];
				CFG_COUNT:  count_q  <= cfg_data;
				default:    method_q <= method_q;
			endcase
		end
	end

	// Antigens in use, clipped to the ring length.
	assign n_act  = ({2'b0, count_q} > 9'(MAX_ANTIGENS)) ? 9'(MAX_ANTIGENS) : {2'b0, count_q};
	assign active = {{(9 - JW){1'b0}}, j_q} < n_act;
	assign j_last = int'(j_q) == MAX_ANTIGENS - 1;

	// Input handshake: one item at a time.
	assign in_stall = state_q != S_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign gi_ok    = int'(gene_index) < MAX_DIMS;
	assign load_we  = in_acc && op == OP_LOAD && int'(antigen_index) < MAX_ANTIGENS && gi_ok;
	assign wr_addr  = AW'(int'(antigen_index) * MAX_DIMS + int'(gene_index));
	assign rd_addr  = AW'(int'(j_q) * MAX_DIMS + int'(gi_q));

	// Antigen store.
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[wr_addr] <= value;
		end
		mem_rd_q <= mem[rd_addr];
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && op == OP_CAND) begin
					if (gi_ok) begin
						state_d = S_CQS;
					end else if (last) begin
						state_d = S_FS;
					end
				end
			end
			S_CQS: state_d = S_CQW;
			S_CQW: if (q_done) state_d = S_RD;
			S_RD:  state_d = S_AQS;
			S_AQS: state_d = active ? S_AQW : S_ACC;
			S_AQW: if (q_done) state_d = S_ACC;
			S_ACC: begin
				if (j_last) begin
					state_d = last_q ? S_FS : S_IDLE;
				end else begin
					state_d = S_RD;
				end
			end
			S_FS:   state_d = (active && method_q == METHOD_EUCL) ? S_FW : S_FA;
			S_FW:   if (r_done) state_d = S_FA;
			S_FA:   state_d = j_last ? S_EMIT : S_FS;
			S_EMIT: if (emit_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		q_start    = 1'b0;
		q_v        = v_q;
		r_start    = 1'b0;
		ring_shift = 1'b0;
		case (state_q)
			S_CQS: q_start = 1'b1;
			S_AQS: begin
				q_start = active;
				q_v     = mem_rd_q;
			end
			S_ACC: ring_shift = 1'b1;
			S_FS:  r_start = active && method_q == METHOD_EUCL;
			S_FA:  ring_shift = 1'b1;
			default: q_start = 1'b0;
		endcase
	end

	assign emit_go = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Squared difference against the antigen just read.
	assign diff = {v_q[31], v_q} - {mem_rd_q[31], mem_rd_q};
	assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

	// Saturating updates of the accumulators.
	assign sq_sum   = {1'b0, ring[0]} + {1'b0, sq_q};
	assign pc       = popcount(qx_q & q_val);
	assign ovl_next = {1'b0, overlap_q} + 49'(pc);
	assign sum_next = {1'b0, sum_q} + 49'(root);

	always_comb begin
		ring_tail = ring[0];
		if (state_q == S_FA) begin
			ring_tail = '0;
		end else if (active) begin
			ring_tail = sq_sum[64] ? '1 : sq_sum[63:0];
		end
	end

	// Accumulators and candidate fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlap_q   <= '0;
			sum_q       <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						j_q   <= '0;
						sum_q <= '0;
					end
				end
				S_ACC: begin
					if (active) begin
						overlap_q <= (ovl_next > OVL_LIMIT) ? OVL_LIMIT[47:0] : ovl_next[47:0];
					end
					j_q <= j_last ? '0 : j_q + JW'(1);
				end
				S_FA: begin
					if (active && method_q == METHOD_EUCL) begin
						sum_q <= (sum_next > POS_LIMIT) ? POS_LIMIT[47:0] : sum_next[47:0];
					end
					j_q <= j_last ? '0 : j_q + JW'(1);
				end
				S_EMIT: begin
					if (emit_go) begin
						overlap_q <= '0;
					end
				end
				default: j_q <= j_q;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			gi_q   <= gene_index;
			v_q    <= value;
			lb_q   <= lower_bound;
			ub_q   <= upper_bound;
			last_q <= last;
		end
		if (state_q == S_CQW && q_done) begin
			qx_q <= q_val;
		end
		if (state_q == S_AQS) begin
			sq_q <= 64'(mag[31:0]) * 64'(mag[31:0]);
		end
		if (state_q == S_EMIT && emit_go) begin
			dist_q <= (method_q == METHOD_EUCL) ? sum_q : 48'(48'd0 - overlap_q);
		end
	end

	pda_quant #(
		.QB(QUANT_BITS)
	) u_quant (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (q_start),
		.v      (q_v),
		.lb     (lb_q),
		.ub     (ub_q),
		.done   (q_done),
		.q      (q_val)
	);

	pda_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (r_start),
		.din    (ring[0]),
		.done   (r_done),
		.root   (root)
	);

	// Ring of per-antigen sums; the head cell is updated and sent to the tail.
	for (genvar k = 0; k < MAX_ANTIGENS; k++) begin : g_ring
		pda_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ring_shift),
			.din    ((k == MAX_ANTIGENS - 1) ? ring_tail : ring[(k + 1) % MAX_ANTIGENS]),
			.dout   (ring[k])
		);
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_q;

	// The quantizer only finishes while the sequencer waits for it.
	a_quant_done: assert property (@(posedge clk) disable iff (!arst_n)
		q_done |-> (state_q == S_CQW || state_q == S_AQW))
		else $error("quantizer done outside a wait state");

	// The overlap total never passes its saturation limit.
	a_ovl_limit: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, overlap_q} <= OVL_LIMIT)
		else $error("overlap total above limit");

	// A result leaves the emit state into the output register.
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && emit_go) |=> (out_valid && state_q == S_IDLE))
		else $error("emitted result not presented");

	// The square root unit only finishes while the sequencer waits for it.
	a_root_done: assert property (@(posedge clk) disable iff (!arst_n)
		r_done |-> state_q == S_FW)
		else $error("square root done outside its wait state");
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the population distance accumulator.
`timescale 1ns / 100ps

module tb_top;
	import pda_pkg::*;

	localparam int NANT = 64;
	localparam int NDIM = 16;
	localparam int QB   = 25;

	typedef struct packed {
		logic               op;
		logic [5:0]         antigen_index;
		logic [3:0]         gene_index;
		logic signed [31:0] value;
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
		logic               last;
	} gene_item_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	gene_item_t cur_item;
	logic out_valid;
	logic out_stall;
	logic signed [47:0] distance;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [6:0] cfg_data;

	population_distance_accumulator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(cur_item.op), .antigen_index(cur_item.antigen_index),
		.gene_index(cur_item.gene_index), .value(cur_item.value),
		.lower_bound(cur_item.lower_bound), .upper_bound(cur_item.upper_bound),
		.last(cur_item.last),
		.out_valid(out_valid), .out_stall(out_stall), .distance(distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: population, per-antigen square sums, overlap total.
	logic [31:0] pop_mem [NANT*NDIM];
	logic [63:0] sq_sums [NANT];
	logic [47:0] ovl_total;
	logic        mdl_method;
	logic [6:0]  mdl_count;

	gene_item_t       pending_genes[$];
	logic signed [47:0] expected_dist[$];
	int  fail_count;
	bit  calm;
	int  in_gap;
	int  out_gap;
	longint accepted_items;

	// Sampled stall of the input channel, taken at the rising edge.
	logic in_stall_q;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	initial begin
		#80ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [63:0] quant(longint v, longint lb, longint ub);
		longint d;
		longint r;
		logic [63:0] top;
		top = (64'd1 << QB) - 64'd1;
		if (ub <= lb) return 64'd0;
		d = v - lb;
		r = ub - lb;
		if (d <= 0) return 64'd0;
		if (d >= r) return top;
		return (64'(d) * top) / 64'(r);
	endfunction

	function automatic logic [63:0] root64(logic [63:0] s);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Advance the predictor by one accepted transaction.
	task automatic predict_gene(gene_item_t it);
		int n;
		longint v;
		longint a;
		longint lb;
		longint ub;
		longint df;
		logic [63:0] qx;
		logic [63:0] sq;
		logic [63:0] tot;
		logic [63:0] sum;
		n = (mdl_count > NANT) ? NANT : int'(mdl_count);
		if (it.op == OP_LOAD) begin
			pop_mem[it.antigen_index*NDIM + it.gene_index] = it.value;
			return;
		end
		v = $signed(it.value);
		lb = $signed(it.lower_bound);
		ub = $signed(it.upper_bound);
		qx = quant(v, lb, ub);
		tot = ovl_total;
		for (int j = 0; j < n; j++) begin
			a = $signed(pop_mem[j*NDIM + it.gene_index]);
			df = v - a;
			if (df < 0) df = -df;
			sq = 64'(df) * 64'(df);
			tot = tot + 64'($countones(qx & quant(a, lb, ub)));
			if (tot > (64'd1 << 47)) tot = 64'd1 << 47;
			if (sq_sums[j] > ~sq) sq_sums[j] = '1;
			else sq_sums[j] = sq_sums[j] + sq;
		end
		ovl_total = tot[47:0];
		if (!it.last) return;
		if (mdl_method == METHOD_BITS) begin
			expected_dist.push_back(-$signed(ovl_total));
		end else begin
			sum = 0;
			for (int j = 0; j < n; j++) begin
				sum = sum + root64(sq_sums[j]);
				if (sum > (64'd1 << 47) - 1) sum = (64'd1 << 47) - 1;
			end
			expected_dist.push_back(sum[47:0]);
		end
		for (int j = 0; j < NANT; j++) sq_sums[j] = 0;
		ovl_total = 0;
	endtask

	// Driver: presents queued genes and advances on acceptance.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall_q) begin
				void'(pending_genes.pop_front());
			end
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_genes.size() > 0) begin
				if (!calm && (!in_valid || !in_stall_q) && $urandom_range(0, 15) == 0) begin
					in_gap <= $urandom_range(1, 19);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					cur_item <= pending_genes[0];
				end
			end else begin
				in_valid <= 1'b0;
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				out_gap <= $urandom_range(1, 19);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: predict on input acceptance, check on output acceptance.
	always @(posedge clk) begin
		in_stall_q <= in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_gene(cur_item);
				accepted_items <= accepted_items + 1;
			end
			if (out_valid && !out_stall) begin
				if (expected_dist.size() == 0) begin
					$error("distance: unexpected transaction, actual %0d", distance);
					fail_count++;
				end else if (distance !== expected_dist[0]) begin
					$error("distance: expected %0d, actual %0d", expected_dist[0], distance);
					fail_count++;
					void'(expected_dist.pop_front());
				end else begin
					void'(expected_dist.pop_front());
				end
			end
		end
	end

	task automatic write_reg(logic idx, logic [6:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_METHOD) mdl_method = data[0];
		else mdl_count = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic gene_item_t load_gene(int ai, int gi, logic [31:0] v);
		gene_item_t it;
		it = '0;
		it.op = OP_LOAD;
		it.antigen_index = 6'(ai);
		it.gene_index = 4'(gi);
		it.value = v;
		it.lower_bound = $urandom;
		it.upper_bound = $urandom;
		it.last = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 255) - 128;
			default: return $urandom;
		endcase
	endfunction

	function automatic gene_item_t cand_gene(int gi, bit fin);
		gene_item_t it;
		logic signed [31:0] p;
		logic signed [31:0] q;
		it = '0;
		it.op = OP_CAND;
		it.antigen_index = 6'($urandom);
		it.gene_index = 4'(gi);
		it.value = rand_val();
		p = rand_val();
		q = rand_val();
		if ($urandom_range(0, 9) == 0) begin
			it.lower_bound = p;
			it.upper_bound = q;
		end else begin
			it.lower_bound = (p < q) ? p : q;
			it.upper_bound = (p < q) ? q : p;
			if (p == q) it.upper_bound = p + 32'sd1;
			if ($urandom_range(0, 3) == 0) begin
				it.lower_bound = -$signed(32'($urandom_range(1, 1 << 20)));
				it.upper_bound = $urandom_range(1, 1 << 20);
				it.value = $urandom_range(0, 1 << 21) - (1 << 20);
			end
		end
		it.last = fin;
		return it;
	endfunction

	// Wait until the driver has sent every queued gene and all results have arrived.
	task automatic drain_queue();
		while (pending_genes.size() > 0 || expected_dist.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Whole population load with random values.
	task automatic fill_population();
		for (int a = 0; a < NANT; a++)
			for (int g = 0; g < NDIM; g++)
				pending_genes.push_back(load_gene(a, g, rand_val()));
	endtask

	// One candidate of the given length over random gene positions.
	task automatic push_candidate(int len);
		for (int k = 0; k < len; k++)
			pending_genes.push_back(cand_gene($urandom_range(0, NDIM-1), k == len-1));
	endtask

	initial begin
		int counts [6];
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cur_item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_METHOD;
		cfg_data = '0;
		fail_count = 0;
		calm = 0;
		in_gap = 0;
		out_gap = 0;
		in_stall_q = 1'b1;
		accepted_items = 0;
		mdl_method = METHOD_BITS;
		mdl_count = 7'd1;
		ovl_total = 0;
		for (int j = 0; j < NANT; j++) sq_sums[j] = 0;
		for (int j = 0; j < NANT*NDIM; j++) pop_mem[j] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every entry is written up front so no unwritten entry is ever read.
		fill_population();
		drain_queue();

		// Directed: extremes, bad bounds, repeated gene, both methods.
		write_reg(CFG_COUNT, 7'd1);
		begin
			gene_item_t it;
			it = cand_gene(0, 0);
			it.value = 32'h7FFF_FFFF; it.lower_bound = 32'h8000_0000;
			it.upper_bound = 32'h7FFF_FFFF;
			pending_genes.push_back(it);
			it.value = 32'h8000_0000; it.gene_index = 4'hF;
			pending_genes.push_back(it);
			it.upper_bound = 32'h8000_0000; it.lower_bound = 32'h7FFF_FFFF;
			it.gene_index = 4'h0;
			pending_genes.push_back(it);
			it.last = 1'b1;
			pending_genes.push_back(it);
		end
		pending_genes.push_back(load_gene(0, 3, 32'h8000_0000));
		pending_genes.push_back(load_gene(63, 15, 32'h7FFF_FFFF));
		push_candidate(3);
		drain_queue();
		write_reg(CFG_METHOD, 7'(METHOD_EUCL));
		write_reg(CFG_COUNT, 7'd64);
		push_candidate(2);
		drain_queue();
		write_reg(CFG_COUNT, 7'd127);
		push_candidate(2);
		drain_queue();
		write_reg(CFG_COUNT, 7'd0);
		push_candidate(1);
		drain_queue();
		write_reg(CFG_METHOD, 7'(METHOD_BITS));
		write_reg(CFG_COUNT, 7'd100);
		push_candidate(2);
		drain_queue();

		// Random phases over several register settings.
		counts = '{1, 2, 7, 64, 0, 33};
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(CFG_METHOD, 7'($urandom_range(0, 1)));
			write_reg(CFG_COUNT, (ph < 6) ? 7'(counts[ph]) : 7'($urandom_range(0, 127)));
			if (ph == 11) calm = 1;
			for (int c = 0; c < 2; c++) begin
				if ($urandom_range(0, 4) == 0)
					for (int k = 0; k < 3; k++)
						pending_genes.push_back(load_gene($urandom_range(0, NANT-1),
							$urandom_range(0, NDIM-1), rand_val()));
				push_candidate($urandom_range(1, 9));
			end
			drain_queue();
		end

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ population_distance_accumulator_top.f @@
rtl/core/pda_pkg.sv
rtl/core/pda_cell.sv
rtl/core/pda_quant.sv
rtl/core/pda_isqrt.sv
rtl/core/population_distance_accumulator_top.sv
tb/tb_top.sv
